// File: hdl/assert_macros.svh
// Assertion macros shared by the filterbank modules.
// Each module that uses them has clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define MFB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define MFB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define MFB_ASSERT(lbl, prop, msg)
`define MFB_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: hdl/mfb_pkg.sv
package mfb_pkg;

  localparam int unsigned BinW    = 10;
  localparam int unsigned PowerW  = 32;
  localparam int unsigned WeightW = 16;
  localparam int unsigned FloorW  = 16;
  localparam int unsigned SumW    = 48;
  localparam int unsigned IndexW  = 6;
  localparam int unsigned RecipW  = 37;

  localparam logic [BinW-1:0] CountMax = 10'd1023;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam longint unsigned MelTopQ28 = 64'd512070953;
  localparam longint unsigned Q28One    = 64'd268435456;

  typedef struct packed {
    logic [PowerW-1:0] power;
    logic [BinW-1:0]   bin;
    logic              last;
  } bin_req_t;

  // Edge bin N of the mel filterbank, evaluated at elaboration only.
  function automatic logic [BinW-1:0] edge_bin(input int unsigned N,
                                               input int unsigned Banks,
                                               input int unsigned FftSize);
    longint unsigned parts_x;
    longint unsigned x;
    longint unsigned sum;
    longint unsigned term;
    longint unsigned num;
    longint unsigned Parts;
    longint unsigned Den;
    longint unsigned K;
    logic            done;
    Parts = longint'(Banks) + 64'd1;
    parts_x = MelTopQ28 * longint'(N);
    x = parts_x / Parts;
    sum = Q28One;
    term = Q28One;
    done = 1'b0;
    for (K = 1; K < 64; K++) begin
      if (!done) begin
        term = (term * x) >> 28;
        term = term / K;
        if (term == 0) begin
          done = 1'b1;
        end else begin
          sum = sum + term;
        end
      end
    end
    num = (longint'(FftSize) + 64'd1) * 64'd700 * (sum - Q28One);
    Den = 64'd16000 << 28;
    return BinW'(num / Den);
  endfunction

  // Rounded-up reciprocal 2^36 / D, used to turn the slope division into
  // a multiplication.
  function automatic logic [RecipW-1:0] recip_q36(input logic [BinW-1:0] D);
    longint unsigned Dw;
    Dw = 64'(D);
    if (Dw == 0) begin
      return '0;
    end
    return RecipW'(((64'd1 << 36) + Dw - 64'd1) / Dw);
  endfunction

endpackage

// File: hdl/mfb_queue.sv
`include "assert_macros.svh"

module mfb_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  mfb_pkg::bin_req_t req_i,
  output logic              full_o,
  input  logic              rd_i,
  output logic              empty_o,
  output mfb_pkg::bin_req_t req_o
);

  mfb_pkg::bin_req_t                   mem_q [mfb_pkg::QueueDepth];
  logic [mfb_pkg::QueuePtrW-1:0]       wr_ptr_q;
  logic [mfb_pkg::QueuePtrW-1:0]       rd_ptr_q;
  logic [mfb_pkg::QueueCntW-1:0]       count_q;
  logic                                do_wr;
  logic                                do_rd;

  assign full_o  = (count_q == mfb_pkg::QueueCntW'(mfb_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign req_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + mfb_pkg::QueuePtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + mfb_pkg::QueuePtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + mfb_pkg::QueueCntW'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - mfb_pkg::QueueCntW'(1);
      end
    end
  end

  `MFB_ASSERT(a_queue_bound, count_q <= mfb_pkg::QueueCntW'(mfb_pkg::QueueDepth), "queue count exceeds depth")

endmodule

// File: hdl/mfb_front.sv
module mfb_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [31:0]       bin_power_i,
  input  logic              frame_end_i,
  input  logic              q_full_i,
  output logic              q_wr_o,
  output mfb_pkg::bin_req_t q_req_o
);

  logic [mfb_pkg::BinW-1:0] bin_count_q;
  logic [mfb_pkg::BinW-1:0] bin_count_d;
  logic                     accept;

  assign full   = q_full_i;
  assign accept = push && !q_full_i;
  assign q_wr_o = accept;

  assign q_req_o.power = bin_power_i;
  assign q_req_o.bin   = bin_count_q;
  assign q_req_o.last  = frame_end_i;

  // The bin counter restarts after a frame and holds at its maximum.
  always_comb begin
    bin_count_d = bin_count_q;
    if (accept) begin
      if (frame_end_i) begin
        bin_count_d = '0;
      end else if (bin_count_q != mfb_pkg::CountMax) begin
        bin_count_d = bin_count_q + mfb_pkg::BinW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_count_q <= '0;
    end else begin
      bin_count_q <= bin_count_d;
    end
  end

endmodule

// File: hdl/mfb_back.sv
`include "assert_macros.svh"

module mfb_back #(
  parameter int unsigned BANKS    = 26,
  parameter int unsigned FFT_SIZE = 512
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic              q_empty_i,
  input  mfb_pkg::bin_req_t q_req_i,
  output logic              q_rd_o,
  output logic              empty,
  input  logic              pop,
  output logic [5:0]        bank_index_o,
  output logic [47:0]       bank_energy_o,
  output logic              last_bank_o
);

  localparam int unsigned IdxW = (BANKS > 1) ? $clog2(BANKS) : 1;

  logic [mfb_pkg::FloorW-1:0]  zero_floor_q;

  logic                        a_valid_q;
  logic                        a_last_q;
  logic [mfb_pkg::PowerW-1:0]  a_power_q;
  logic [mfb_pkg::WeightW-1:0] a_weight_q [BANKS];
  logic [mfb_pkg::WeightW-1:0] weight_d   [BANKS];

  logic                        b_valid_q;
  logic                        b_last_q;
  logic [mfb_pkg::PowerW-1:0]  b_prod_q [BANKS];
  logic [mfb_pkg::PowerW-1:0]  prod_d   [BANKS];

  logic [mfb_pkg::SumW-1:0]    sums_q [BANKS];
  logic [mfb_pkg::SumW-1:0]    sums_d [BANKS];

  logic                        drain_q;
  logic [IdxW-1:0]             drain_idx_q;
  logic                        out_valid_q;
  logic [IdxW-1:0]             out_idx_q;
  logic [mfb_pkg::SumW-1:0]    out_energy_q;
  logic                        out_last_q;

  logic                        advance;
  logic                        out_load;
  logic                        drain_last;

  assign advance    = !drain_q;
  assign q_rd_o     = advance && !q_empty_i;
  assign drain_last = (drain_idx_q == IdxW'(BANKS - 1));
  assign out_load   = drain_q && (!out_valid_q || pop);

  assign empty         = !out_valid_q;
  assign bank_index_o  = 6'(out_idx_q);
  assign bank_energy_o = out_energy_q;
  assign last_bank_o   = out_last_q;

  for (genvar g = 0; g < BANKS; g++) begin : g_bank
    localparam logic [mfb_pkg::BinW-1:0] Lo =
      mfb_pkg::edge_bin(g, BANKS, FFT_SIZE);
    localparam logic [mfb_pkg::BinW-1:0] Mid =
      mfb_pkg::edge_bin(g + 1, BANKS, FFT_SIZE);
    localparam logic [mfb_pkg::BinW-1:0] Hi =
      mfb_pkg::edge_bin(g + 2, BANKS, FFT_SIZE);
    localparam logic [mfb_pkg::BinW-1:0]   DRise = Mid - Lo;
    localparam logic [mfb_pkg::BinW-1:0]   DFall = Hi - Mid;
    localparam logic [mfb_pkg::RecipW-1:0] MRise = mfb_pkg::recip_q36(DRise);
    localparam logic [mfb_pkg::RecipW-1:0] MFall = mfb_pkg::recip_q36(DFall);

    logic                                          rise;
    logic                                          fall;
    logic                                          at_peak;
    logic [mfb_pkg::BinW-1:0]                      num;
    logic [mfb_pkg::RecipW-1:0]                    mul;
    logic [mfb_pkg::BinW+mfb_pkg::RecipW-1:0]      quot;
    logic [mfb_pkg::PowerW+mfb_pkg::WeightW-1:0]   scaled;
    logic [mfb_pkg::SumW:0]                        sum_wide;
    logic [mfb_pkg::PowerW-1:0]                    addend;

    assign rise = (q_req_i.bin >= Lo) && (q_req_i.bin <= Mid) && (DRise != '0);
    assign fall = (q_req_i.bin >= Mid) && (q_req_i.bin <= Hi) && (DFall != '0);
    assign num  = rise ? (q_req_i.bin - Lo) : (Hi - q_req_i.bin);
    assign mul  = rise ? MRise : MFall;
    assign at_peak = rise ? (num == DRise) : (num == DFall);
    assign quot = num * mul;

    // A weight of exactly one does not fit Q0.16 and is clipped.
    assign weight_d[g] = (!rise && !fall) ? '0 :
                         at_peak          ? '1 : quot[35:20];

    assign scaled    = a_power_q * a_weight_q[g];
    assign prod_d[g] = scaled[mfb_pkg::PowerW+mfb_pkg::WeightW-1:mfb_pkg::WeightW];

    assign addend   = (b_prod_q[g] == '0) ? mfb_pkg::PowerW'(zero_floor_q) : b_prod_q[g];
    assign sum_wide = {1'b0, sums_q[g]} + (mfb_pkg::SumW + 1)'(addend);
    assign sums_d[g] = sum_wide[mfb_pkg::SumW] ? '1 : sum_wide[mfb_pkg::SumW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      a_last_q  <= q_req_i.last;
      a_power_q <= q_req_i.power;
      b_last_q  <= a_last_q;
      for (int i = 0; i < BANKS; i++) begin
        a_weight_q[i] <= weight_d[i];
        b_prod_q[i]   <= prod_d[i];
      end
    end
    if (out_load) begin
      out_idx_q    <= drain_idx_q;
      out_energy_q <= sums_q[drain_idx_q];
      out_last_q   <= drain_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_floor_q <= mfb_pkg::FloorW'(1);
      a_valid_q    <= 1'b0;
      b_valid_q    <= 1'b0;
      drain_q      <= 1'b0;
      drain_idx_q  <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < BANKS; i++) begin
        sums_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        zero_floor_q <= cfg_wdata_i;
      end
      if (advance) begin
        a_valid_q <= q_rd_o;
        b_valid_q <= a_valid_q;
        if (b_valid_q) begin
          for (int i = 0; i < BANKS; i++) begin
            sums_q[i] <= sums_d[i];
          end
          if (b_last_q) begin
            drain_q     <= 1'b1;
            drain_idx_q <= '0;
          end
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        if (drain_last) begin
          drain_q     <= 1'b0;
          drain_idx_q <= '0;
          for (int i = 0; i < BANKS; i++) begin
            sums_q[i] <= '0;
          end
        end else begin
          drain_idx_q <= drain_idx_q + IdxW'(1);
        end
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  `MFB_ASSERT(a_drain_starts, (advance && b_valid_q && b_last_q) |=> (drain_q && drain_idx_q == '0), "frame end did not start the readout")
  `MFB_ASSERT(a_drain_freezes, (drain_q && !out_load) |=> ($stable(b_valid_q) && $stable(a_valid_q)), "pipeline moved during readout")
  `MFB_ASSERT(a_drain_clears, (out_load && drain_last) |=> (!drain_q && sums_q[0] == '0), "sums not cleared after readout")

endmodule

// File: hdl/mel_filterbank_accumulator_unit.sv
// Mel filterbank accumulator. FFT power bins (unsigned Q16.16) are pushed one per
// cycle while full is low, counted from bin 0; frame_end_i marks the last bin of a
// frame. Each bin passes a two-entry queue and a three-stage pipeline (weights,
// products, bank update) in which all BANKS triangular filters are applied in
// parallel, so bins are taken at one per clock outside the readout, and the first
// sum of a frame reaches the outputs through the queue, the weight and product
// registers, the bank update and the output register. A zero product adds the
// zero_floor register (reset 1, written through cfg_we_i and cfg_wdata_i) instead.
// After the marked bin, the pipeline pauses while the BANKS saturated Q32.16 sums
// are read out through the output register, one bank per cycle while pop keeps it
// free, bank 0 first, and then cleared. The filter edges are fixed at build time
// from BANKS and FFT_SIZE.
module mel_filterbank_accumulator_unit #(
  parameter int unsigned BANKS    = 26,
  parameter int unsigned FFT_SIZE = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [31:0] bin_power_i,
  input  logic        frame_end_i,
  output logic        empty,
  input  logic        pop,
  output logic [5:0]  bank_index_o,
  output logic [47:0] bank_energy_o,
  output logic        last_bank_o
);

  mfb_pkg::bin_req_t wr_req;
  mfb_pkg::bin_req_t rd_req;
  logic              q_wr;
  logic              q_rd;
  logic              q_full;
  logic              q_empty;

  mfb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .bin_power_i (bin_power_i),
    .frame_end_i (frame_end_i),
    .q_full_i    (q_full),
    .q_wr_o      (q_wr),
    .q_req_o     (wr_req)
  );

  mfb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .req_i   (wr_req),
    .full_o  (q_full),
    .rd_i    (q_rd),
    .empty_o (q_empty),
    .req_o   (rd_req)
  );

  mfb_back #(
    .BANKS    (BANKS),
    .FFT_SIZE (FFT_SIZE)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .q_empty_i     (q_empty),
    .q_req_i       (rd_req),
    .q_rd_o        (q_rd),
    .empty         (empty),
    .pop           (pop),
    .bank_index_o  (bank_index_o),
    .bank_energy_o (bank_energy_o),
    .last_bank_o   (last_bank_o)
  );

endmodule
